FILE: rtl/core/canny_nms_hysteresis_defines.svh
// Assertion macros used by the cnh_back part of the canny_nms_hysteresis RTL.
`ifndef CANNY_NMS_HYSTERESIS_DEFINES_SVH
`define CANNY_NMS_HYSTERESIS_DEFINES_SVH

// Same-cycle implication, off during reset.
`define CNH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cnh assertion failed");

// Next-cycle implication, off during reset.
`define CNH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cnh assertion failed");

`endif

FILE: rtl/core/cnh_pkg.sv
// Shared types, constants and helpers of the Canny suppression and hysteresis block.
package cnh_pkg;

   localparam int DEF_MAX_WIDTH   = 512;
   localparam int DEF_MAX_HEIGHT  = 512;
   localparam int DEF_STACK_DEPTH = 262144;

   localparam int GRAD_W = 16;
   localparam int MAG_W  = 32;
   localparam int CSR_W  = 16;
   localparam int CSR_IDX_W = 3;

   // tan(22.5 deg) in Q15
   localparam logic [13:0] TAN22_Q15 = 14'd13573;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd3;

   // edge map codes
   typedef enum logic [1:0] {
      CODE_CAND = 2'd0,
      CODE_NONE = 2'd1,
      CODE_EDGE = 2'd2
   } map_code_type;

   // queue entry kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_END   = 1'b1;

   typedef struct packed {
      logic idle;
      logic loading;
   } fe_status_type;

   typedef struct packed {
      logic [1:0] dr;
      logic [1:0] dc;
   } nbr_type;

   // 8-connected neighbor offsets in trace order, two's complement
   function automatic nbr_type nbr_offset(input logic [2:0] k);
      nbr_type n;
      case (k)
         3'd0: n = '{dr: 2'b00, dc: 2'b11};
         3'd1: n = '{dr: 2'b00, dc: 2'b01};
         3'd2: n = '{dr: 2'b11, dc: 2'b11};
         3'd3: n = '{dr: 2'b11, dc: 2'b00};
         3'd4: n = '{dr: 2'b11, dc: 2'b01};
         3'd5: n = '{dr: 2'b01, dc: 2'b11};
         3'd6: n = '{dr: 2'b01, dc: 2'b00};
         3'd7: n = '{dr: 2'b01, dc: 2'b01};
         default: n = '{dr: 2'b00, dc: 2'b00};
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/core/cnh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cnh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cnh_queue.sv
// Short FIFO between the classifying front and the tracing back.
module cnh_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             flush,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             push, pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_en && !full;
   assign pop      = rd_en && rd_valid;

   // advance pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      if (flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/core/cnh_front.sv
// Front part: magnitudes, three-row window, non-maximum suppression and classification.
module cnh_front import cnh_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           restart,
   input  logic [CSR_W-1:0]                               low_threshold,
   input  logic [CSR_W-1:0]                               high_threshold,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]                 width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]                height_eff,
   input  logic                                           start,
   input  logic signed [GRAD_W-1:0]                       grad_x,
   input  logic signed [GRAD_W-1:0]                       grad_y,
   output fe_status_type                                  status,
   output logic                                           q_wr_en,
   output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+2:0] q_wr_data,
   input  logic                                           q_full
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int CW1 = $clog2(MAX_WIDTH+1);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int RW1 = $clog2(MAX_HEIGHT+1);
   localparam int LB_W = 2*GRAD_W + 2*MAG_W;

   typedef enum logic [7:0] {
      F_IDLE  = 8'b0000_0001,
      F_MUL   = 8'b0000_0010,
      F_RD    = 8'b0000_0100,
      F_SHIFT = 8'b0000_1000,
      F_TAN   = 8'b0001_0000,
      F_DEC   = 8'b0010_0000,
      F_END   = 8'b0100_0000,
      F_DONE  = 8'b1000_0000
   } fe_state_type;

   fe_state_type state_ff, state_in;
   logic [CW1-1:0] col_ff, col_in;
   logic [RW1-1:0] row_ff, row_in;
   logic           seed_flag_ff, seed_flag_in;

   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic [MAG_W-1:0]         sqx_ff, sqy_ff;
   logic [MAG_W-1:0]         low2_ff, high2_ff;
   logic [MAG_W-1:0]         up_ff [3];
   logic [MAG_W-1:0]         md_ff [3];
   logic [MAG_W-1:0]         dn_ff [3];
   logic [2*GRAD_W-1:0]      g_new_ff, g_ctr_ff;
   logic [16:0]              ax_ff;
   logic [30:0]              t22_ff;
   logic [31:0]              ay_ff;
   logic                     diff_ff;

   logic signed [MAG_W-1:0] sqx_c, sqy_c;
   logic [MAG_W-1:0]        mag_sum, lb_m1, lb_m2, new_up, new_md, new_dn, m;
   logic [2*GRAD_W-1:0]     lb_grad;
   logic [LB_W-1:0]         lb_rd_data;
   logic                    lb_we, seed_rd_data, seed_we, rd_issue;
   logic                    is_pad, row_in_frame, center_ok;
   logic signed [GRAD_W-1:0] xs, ys;
   logic [16:0]             ax_c, ay_c;
   logic [32:0]             lim;
   logic                    dir_h, dir_v, keep, flag_eff, above_seed, step_done;
   map_code_type            code;

   assign is_pad       = (col_ff == width_eff);
   assign row_in_frame = (row_ff < height_eff);
   assign center_ok    = (col_ff != '0) && (row_ff != '0);
   assign rd_issue     = (state_ff == F_MUL) || (state_ff == F_RD);

   // squared gradient and new window column
   assign sqx_c   = gx_ff * gx_ff;
   assign sqy_c   = gy_ff * gy_ff;
   assign mag_sum = sqx_ff + sqy_ff;
   assign lb_grad = lb_rd_data[LB_W-1 -: 2*GRAD_W];
   assign lb_m1   = lb_rd_data[2*MAG_W-1 -: MAG_W];
   assign lb_m2   = lb_rd_data[MAG_W-1:0];
   assign new_dn  = (row_in_frame && !is_pad) ? mag_sum : '0;
   assign new_md  = (!is_pad && row_ff != '0) ? lb_m1 : '0;
   assign new_up  = (!is_pad && row_ff >= RW1'(2)) ? lb_m2 : '0;
   assign lb_we   = (state_ff == F_SHIFT) && row_in_frame && !is_pad;

   // line buffer: {gradient of row r-1, magnitude of row r-1, magnitude of row r-2}
   cnh_ram #(.WIDTH(LB_W), .DEPTH(MAX_WIDTH)) u_line_buf (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (col_ff[CW-1:0]),
      .wr_data ({gy_ff, gx_ff, mag_sum, lb_m1}),
      .rd_en   (rd_issue),
      .rd_addr (col_ff[CW-1:0]),
      .rd_data (lb_rd_data)
   );

   // one seed bit per column of the previous row
   cnh_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_seed_row (
      .clock   (clock),
      .wr_en   (seed_we),
      .wr_addr (CW'(col_ff - 1'b1)),
      .wr_data (code == CODE_EDGE),
      .rd_en   (rd_issue),
      .rd_addr (CW'(col_ff - 1'b1)),
      .rd_data (seed_rd_data)
   );

   // direction terms of the center gradient
   assign xs   = g_ctr_ff[GRAD_W-1:0];
   assign ys   = g_ctr_ff[2*GRAD_W-1:GRAD_W];
   assign ax_c = xs[GRAD_W-1] ? (17'd0 - {1'b1, xs}) : {1'b0, xs};
   assign ay_c = ys[GRAD_W-1] ? (17'd0 - {1'b1, ys}) : {1'b0, ys};

   // suppress and classify the center pixel
   assign m          = md_ff[1];
   assign lim        = 33'(t22_ff) + {ax_ff, 16'b0};
   assign dir_h      = (33'(ay_ff) < 33'(t22_ff));
   assign dir_v      = (33'(ay_ff) > lim);
   assign flag_eff   = (col_ff == CW1'(1)) ? 1'b0 : seed_flag_ff;
   assign above_seed = seed_rd_data && (row_ff >= RW1'(2));

   always_comb begin
      if (dir_h) begin
         keep = (m > md_ff[0]) && (m >= md_ff[2]);
      end else if (dir_v) begin
         keep = (m > up_ff[1]) && (m >= dn_ff[1]);
      end else if (diff_ff) begin
         keep = (m > up_ff[2]) && (m > dn_ff[0]);
      end else begin
         keep = (m > up_ff[0]) && (m > dn_ff[2]);
      end
      keep = keep && (m > low2_ff);
      if (!keep) begin
         code = CODE_NONE;
         seed_flag_in = 1'b0;
      end else if (!flag_eff && (m > high2_ff) && !above_seed) begin
         code = CODE_EDGE;
         seed_flag_in = 1'b1;
      end else begin
         code = CODE_CAND;
         seed_flag_in = flag_eff;
      end
   end

   assign seed_we   = (state_ff == F_DEC) && !q_full;
   assign step_done = ((state_ff == F_SHIFT) && !center_ok) || seed_we;

   // queue entry
   always_comb begin
      q_wr_en   = 1'b0;
      q_wr_data = {KIND_PIXEL, code, RW'(row_ff - 1'b1), CW'(col_ff - 1'b1)};
      if (state_ff == F_DEC) begin
         q_wr_en = 1'b1;
      end else if (state_ff == F_END) begin
         q_wr_en   = 1'b1;
         q_wr_data = {KIND_END, CODE_NONE, {(RW+CW){1'b0}}};
      end
   end

   // sequence the steps of a row
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) state_in = F_MUL;
         end
         F_MUL:   state_in = F_SHIFT;
         F_RD:    state_in = F_SHIFT;
         F_SHIFT: begin
            if (center_ok) state_in = F_TAN;
         end
         F_TAN:   state_in = F_DEC;
         F_DEC:   ;
         F_END: begin
            if (!q_full) state_in = F_DONE;
         end
         F_DONE:  ;
         default: state_in = F_IDLE;
      endcase
      if (step_done) begin
         if (row_in_frame) begin
            if (col_ff == width_eff - 1'b1) begin
               col_in   = width_eff;
               state_in = F_RD;
            end else if (is_pad) begin
               col_in   = '0;
               row_in   = row_ff + 1'b1;
               state_in = (row_ff + 1'b1 == height_eff) ? F_RD : F_IDLE;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = F_IDLE;
            end
         end else if (is_pad) begin
            state_in = F_END;
         end else begin
            col_in   = col_ff + 1'b1;
            state_in = F_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff     <= F_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         seed_flag_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (seed_we) seed_flag_ff <= seed_flag_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      low2_ff  <= low_threshold * low_threshold;
      high2_ff <= high_threshold * high_threshold;
      if (state_ff == F_IDLE && start) begin
         gx_ff <= grad_x;
         gy_ff <= grad_y;
      end
      if (state_ff == F_MUL) begin
         sqx_ff <= $unsigned(sqx_c);
         sqy_ff <= $unsigned(sqy_c);
      end
      if (state_ff == F_SHIFT) begin
         up_ff[0] <= (col_ff == '0) ? '0 : up_ff[1];
         md_ff[0] <= (col_ff == '0) ? '0 : md_ff[1];
         dn_ff[0] <= (col_ff == '0) ? '0 : dn_ff[1];
         up_ff[1] <= (col_ff == '0) ? '0 : up_ff[2];
         md_ff[1] <= (col_ff == '0) ? '0 : md_ff[2];
         dn_ff[1] <= (col_ff == '0) ? '0 : dn_ff[2];
         up_ff[2] <= new_up;
         md_ff[2] <= new_md;
         dn_ff[2] <= new_dn;
         g_ctr_ff <= g_new_ff;
         g_new_ff <= lb_grad;
      end
      if (state_ff == F_TAN) begin
         ax_ff   <= ax_c;
         t22_ff  <= 31'(ax_c) * 31'(TAN22_Q15);
         ay_ff   <= {ay_c[16:0], 15'b0};
         diff_ff <= xs[GRAD_W-1] ^ ys[GRAD_W-1];
      end
   end

   assign status.idle    = (state_ff == F_IDLE);
   assign status.loading = row_in_frame;

endmodule

FILE: rtl/core/cnh_back.sv
// Back part: edge map writes, hysteresis trace with a stack, and frame readout.
`include "canny_nms_hysteresis_defines.svh"
module cnh_back import cnh_pkg::*; #(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]                 width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]                height_eff,
   input  logic                                           q_rd_valid,
   input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+2:0] q_rd_data,
   output logic                                           q_rd_en,
   input  logic                                           rd_start,
   output logic                                           read_ready,
   output logic                                           frame_done,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output logic [7:0]                                     rsp_edge_value,
   output logic                                           rsp_last_pixel
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int IDX_W = RW + CW;
   localparam int SPW   = $clog2(STACK_DEPTH+1);

   typedef enum logic [6:0] {
      B_FILL  = 7'b000_0001,
      B_POP   = 7'b000_0010,
      B_PWAIT = 7'b000_0100,
      B_NRD   = 7'b000_1000,
      B_NCHK  = 7'b001_0000,
      B_READY = 7'b010_0000,
      B_RDATA = 7'b100_0000
   } be_state_type;

   be_state_type   state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [2:0]     k_ff, k_in;
   logic [IDX_W-1:0] p_ff, q_ff;
   logic [RW-1:0]  ro_r_ff, ro_r_in;
   logic [CW-1:0]  ro_c_ff, ro_c_in;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_value_ff;
   logic           rsp_last_ff;

   logic             q_kind;
   map_code_type     q_code;
   logic [IDX_W-1:0] q_idx, q_c;
   nbr_type          nb;
   logic [RW+1:0]    nr;
   logic [CW+1:0]    nc;
   logic             in_range, map_we, map_rd_en, push_en, stack_we, last_c;
   logic [1:0]       map_wr_data, map_rd_data;
   logic [IDX_W-1:0] map_wr_addr, map_rd_addr, push_data, stack_rd_data;

   assign q_kind = q_rd_data[IDX_W+2];
   assign q_code = map_code_type'(q_rd_data[IDX_W+1:IDX_W]);
   assign q_idx  = q_rd_data[IDX_W-1:0];

   // neighbor coordinates and border test
   assign nb = nbr_offset(k_ff);
   assign nr = (RW+2)'(p_ff[IDX_W-1:CW]) + {{RW{nb.dr[1]}}, nb.dr};
   assign nc = (CW+2)'(p_ff[CW-1:0]) + {{CW{nb.dc[1]}}, nb.dc};
   assign in_range = !nr[RW+1] && (nr < (RW+2)'(height_eff))
                  && !nc[CW+1] && (nc < (CW+2)'(width_eff));
   assign q_c = {nr[RW-1:0], nc[CW-1:0]};

   assign last_c = ((RW+1)'(ro_r_ff) + 1'b1 == (RW+1)'(height_eff))
                && ((CW+1)'(ro_c_ff) + 1'b1 == (CW+1)'(width_eff));

   // map and stack port control
   always_comb begin
      q_rd_en     = 1'b0;
      map_we      = 1'b0;
      map_wr_addr = q_idx;
      map_wr_data = q_code;
      push_en     = 1'b0;
      push_data   = q_idx;
      map_rd_en   = rd_start;
      map_rd_addr = {ro_r_ff, ro_c_ff};
      case (state_ff)
         B_FILL: begin
            q_rd_en = q_rd_valid;
            if (q_rd_valid && q_kind == KIND_PIXEL) begin
               map_we  = 1'b1;
               push_en = (q_code == CODE_EDGE);
            end
         end
         B_NRD: begin
            map_rd_en   = in_range;
            map_rd_addr = q_c;
         end
         B_NCHK: begin
            if (map_code_type'(map_rd_data) == CODE_CAND) begin
               map_we      = 1'b1;
               map_wr_addr = q_ff;
               map_wr_data = CODE_EDGE;
               push_en     = 1'b1;
               push_data   = q_ff;
            end
         end
         default: ;
      endcase
   end

   assign stack_we = push_en && (sp_ff < SPW'(STACK_DEPTH));

   cnh_ram #(.WIDTH(2), .DEPTH(2**IDX_W)) u_edge_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   cnh_ram #(.WIDTH(IDX_W), .DEPTH(STACK_DEPTH)) u_trace_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr ($clog2(STACK_DEPTH)'(sp_ff)),
      .wr_data (push_data),
      .rd_en   ((state_ff == B_POP) && (sp_ff != '0)),
      .rd_addr ($clog2(STACK_DEPTH)'(sp_ff - 1'b1)),
      .rd_data (stack_rd_data)
   );

   // fill, trace and read out
   always_comb begin
      state_in = state_ff;
      sp_in    = stack_we ? sp_ff + 1'b1 : sp_ff;
      k_in     = k_ff;
      ro_r_in  = ro_r_ff;
      ro_c_in  = ro_c_ff;
      case (state_ff)
         B_FILL: begin
            if (q_rd_valid && q_kind == KIND_END) state_in = B_POP;
         end
         B_POP: begin
            if (sp_ff == '0) begin
               state_in = B_READY;
            end else begin
               sp_in    = sp_ff - 1'b1;
               state_in = B_PWAIT;
            end
         end
         B_PWAIT: begin
            k_in     = '0;
            state_in = B_NRD;
         end
         B_NRD: begin
            if (in_range) begin
               state_in = B_NCHK;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = (k_ff == 3'd7) ? B_POP : B_NRD;
            end
         end
         B_NCHK: begin
            k_in     = k_ff + 1'b1;
            state_in = (k_ff == 3'd7) ? B_POP : B_NRD;
         end
         B_READY: begin
            if (rd_start) state_in = B_RDATA;
         end
         B_RDATA: begin
            state_in = B_READY;
            if ((CW+1)'(ro_c_ff) + 1'b1 == (CW+1)'(width_eff)) begin
               ro_c_in = '0;
               ro_r_in = ro_r_ff + 1'b1;
            end else begin
               ro_c_in = ro_c_ff + 1'b1;
            end
         end
         default: state_in = B_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= B_FILL;
         sp_ff    <= '0;
         k_ff     <= '0;
         ro_r_ff  <= '0;
         ro_c_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         k_ff     <= k_in;
         ro_r_ff  <= ro_r_in;
         ro_c_ff  <= ro_c_in;
      end
   end

   // hold the popped pixel and the neighbor under test
   always_ff @(posedge clock) begin
      if (state_ff == B_PWAIT) p_ff <= stack_rd_data;
      if (state_ff == B_NRD)   q_ff <= q_c;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == B_RDATA) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_RDATA) begin
         rsp_value_ff <= (map_code_type'(map_rd_data) == CODE_EDGE) ? 8'hFF : 8'h00;
         rsp_last_ff  <= last_c;
      end
   end

   assign read_ready     = (state_ff == B_READY) && (!rsp_valid_ff || rsp_ready);
   assign frame_done     = (state_ff == B_RDATA) && last_c;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = rsp_value_ff;
   assign rsp_last_pixel = rsp_last_ff;

   `CNH_ASSERT_IMPLY(a_ready_stack_empty, clock, reset, state_ff == B_READY, sp_ff == '0)
   `CNH_ASSERT_IMPLY(a_map_write_phase, clock, reset, map_we, (state_ff == B_FILL) || (state_ff == B_NCHK))
   `CNH_ASSERT_IMPLY(a_rdata_slot_free, clock, reset, state_ff == B_RDATA, !rsp_valid_ff)
   `CNH_ASSERT_NEXT(a_restart_clears, clock, reset, restart, (state_ff == B_FILL) && (sp_ff == '0))

endmodule

FILE: rtl/core/canny_nms_hysteresis.sv
// Canny edge detector back end. Load a frame of signed x/y gradient pixels in raster
// order (mode 0), then read the edge map pixel by pixel (mode 1): 255 marks an edge,
// last_pixel flags the final pixel. Loads are paced by the sequential suppression
// unit (squared magnitude, one tan22.5 multiply, then compare); the end of each row
// adds a padding step, and the end of the frame adds a pass to suppress the bottom
// row. Hysteresis then traces every seed, testing the eight neighbors of each edge
// pixel popped from the stack through the single edge-map read port. A read passes
// through the edge-map read and the response register. Items of the wrong mode for
// the current phase are taken and dropped. Writing image_width or image_height
// restarts the frame; thresholds take effect at once. No clearing pass is needed
// after reset.
module canny_nms_hysteresis import cnh_pkg::*; #(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic signed [GRAD_W-1:0] req_grad_x,
   input  logic signed [GRAD_W-1:0] req_grad_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_edge_value,
   output logic                     rsp_last_pixel
);

   localparam int CW1 = $clog2(MAX_WIDTH+1);
   localparam int RW1 = $clog2(MAX_HEIGHT+1);
   localparam int QW  = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 3;

   logic [CSR_W-1:0] low_ff, high_ff;
   logic [9:0]       width_ff, height_ff;
   logic [CW1-1:0]   width_eff;
   logic [RW1-1:0]   height_eff;
   fe_status_type    fe_status;
   logic             accept, fe_start, be_rd_start, be_read_ready, be_frame_done;
   logic             restart, csr_restart;
   logic             q_wr_en, q_full, q_rd_en, q_rd_valid;
   logic [QW-1:0]    q_wr_data, q_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= '0;
         high_ff   <= '0;
         width_ff  <= 10'd512;
         height_ff <= 10'd512;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOW_THRESHOLD:  low_ff    <= csr_wdata;
            CSR_HIGH_THRESHOLD: high_ff   <= csr_wdata;
            CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata[9:0];
            CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // clamp frame size to the supported range
   always_comb begin
      if (width_ff == '0) begin
         width_eff = CW1'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = CW1'(MAX_WIDTH);
      end else begin
         width_eff = CW1'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = RW1'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = RW1'(MAX_HEIGHT);
      end else begin
         height_eff = RW1'(height_ff);
      end
   end

   assign csr_restart = csr_we && ((csr_index == CSR_IMAGE_WIDTH)
                                || (csr_index == CSR_IMAGE_HEIGHT));
   assign restart     = csr_restart || be_frame_done;

   // steer requests by frame phase
   assign req_ready   = fe_status.loading ? fe_status.idle : be_read_ready;
   assign accept      = req_valid && req_ready;
   assign fe_start    = accept && fe_status.loading && !req_mode;
   assign be_rd_start = accept && !fe_status.loading && req_mode;

   cnh_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock          (clock),
      .reset          (reset),
      .restart        (restart),
      .low_threshold  (low_ff),
      .high_threshold (high_ff),
      .width_eff      (width_eff),
      .height_eff     (height_eff),
      .start          (fe_start),
      .grad_x         (req_grad_x),
      .grad_y         (req_grad_y),
      .status         (fe_status),
      .q_wr_en        (q_wr_en),
      .q_wr_data      (q_wr_data),
      .q_full         (q_full)
   );

   cnh_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .flush    (restart),
      .wr_en    (q_wr_en),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_en    (q_rd_en),
      .rd_valid (q_rd_valid),
      .rd_data  (q_rd_data)
   );

   cnh_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .restart        (restart),
      .width_eff      (width_eff),
      .height_eff     (height_eff),
      .q_rd_valid     (q_rd_valid),
      .q_rd_data      (q_rd_data),
      .q_rd_en        (q_rd_en),
      .rd_start       (be_rd_start),
      .read_ready     (be_read_ready),
      .frame_done     (be_frame_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule
